/* rtl/core/ntt_mod_prime_transform_unit_macros.svh */
// Assertion macros shared by the transform unit RTL.
`ifndef NTT_MOD_PRIME_TRANSFORM_UNIT_MACROS_SVH
`define NTT_MOD_PRIME_TRANSFORM_UNIT_MACROS_SVH

// Same-cycle implication, sampled on the rising clock edge outside reset.
`define NTT_ASSERT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> cons) \
    else $error(msg);

// Next-cycle implication, sampled on the rising clock edge outside reset.
`define NTT_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> cons) \
    else $error(msg);

`endif

/* rtl/core/ntt_pkg.sv */
// Package with the types, constants and helper functions of the transform unit.
`timescale 1ns / 1ps
`default_nettype none
package ntt_pkg;

  localparam int LOGN = 10;
  localparam int N    = 1 << LOGN;
  localparam int CW   = 30;
  localparam int LGW  = $clog2(LOGN + 1);
  localparam int JW   = LOGN - 1;

  typedef logic [CW-1:0]   coef_t;
  typedef logic [LOGN-1:0] addr_t;

  localparam coef_t PRIME = 30'd998244353;
  localparam coef_t ROOT  = 30'd3;
  localparam coef_t PM1   = PRIME - 30'd1;
  localparam coef_t PM2   = PRIME - 30'd2;

  localparam logic [1:0] ACT_WRITE = 2'd0;
  localparam logic [1:0] ACT_RUN   = 2'd1;
  localparam logic [1:0] ACT_READ  = 2'd2;

  localparam logic [1:0] CFG_LOG_LENGTH = 2'd0;
  localparam logic [1:0] CFG_DIRECTION  = 2'd1;

  typedef enum logic [2:0] {
    WSEL_IN, WSEL_RD, WSEL_X, WSEL_SUM, WSEL_DIFF, WSEL_PROD
  } wsel_e;

  typedef enum logic [2:0] {
    MSEL_W_RD, MSEL_W_ACC, MSEL_ACC_B, MSEL_B_B, MSEL_ACC_RD
  } msel_e;

  typedef struct packed {
    logic  rd_en;
    addr_t rd_addr;
    logic  wr_en;
    addr_t wr_addr;
    wsel_e wr_sel;
    logic  x_ld;
    logic  y_ld;
    logic  w_one;
    logic  w_ld;
    logic  mul_start;
    msel_e mul_sel;
    logic  pow_init;
    coef_t pow_base;
    logic  acc_ld;
    logic  b_ld;
  } cmd_t;

  typedef struct packed {
    logic mul_busy;
    logic mul_done;
  } sts_t;

  function automatic coef_t mod_add(coef_t a, coef_t b);
    logic [CW:0] s;
    logic [CW:0] t;
    s = {1'b0, a} + {1'b0, b};
    t = s - {1'b0, PRIME};
    return (s >= {1'b0, PRIME}) ? t[CW-1:0] : s[CW-1:0];
  endfunction

  function automatic coef_t mod_sub(coef_t a, coef_t b);
    logic [CW:0] s;
    logic [CW:0] t;
    s = {1'b0, a} + {1'b0, PRIME} - {1'b0, b};
    t = {1'b0, a} - {1'b0, b};
    return (a >= b) ? t[CW-1:0] : s[CW-1:0];
  endfunction

  // Reverses the low lg bits of an index.
  function automatic addr_t bit_rev(addr_t v, logic [LGW-1:0] lg);
    addr_t r;
    r = '0;
    for (int k = 0; k < LOGN; k++) begin
      r[LOGN-1-k] = v[k];
    end
    return r >> (LGW'(LOGN) - lg);
  endfunction

endpackage
`default_nettype wire

/* rtl/core/ntt_mulmod.sv */
// Bit-serial modular multiplier, one bit of the second operand per cycle.
`timescale 1ns / 1ps
`default_nettype none
module ntt_mulmod import ntt_pkg::*; (
  input  wire   clk_i,
  input  wire   rst_ni,
  input  wire   start_i,
  input  coef_t a_i,
  input  coef_t b_i,
  output coef_t prod_o,
  output logic  busy_o,
  output logic  done_o
);

  localparam int CNT_W = $clog2(CW);
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(CW - 1);

  logic             busy_q;
  logic             done_q;
  logic [CNT_W-1:0] cnt_q;
  coef_t            a_q;
  coef_t            b_q;
  coef_t            acc_q;
  coef_t            dbl;
  coef_t            step;

  // Horner form from the top bit: acc = 2 * acc + bit * a, reduced each step.
  assign dbl  = mod_add(acc_q, acc_q);
  assign step = mod_add(dbl, b_q[CW-1] ? a_q : '0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == CNT_LAST) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      a_q   <= a_i;
      b_q   <= b_i;
      acc_q <= '0;
    end else if (busy_q) begin
      b_q   <= {b_q[CW-2:0], 1'b0};
      acc_q <= step;
    end
  end

  assign prod_o = acc_q;
  assign busy_o = busy_q;
  assign done_o = done_q;

endmodule
`default_nettype wire

/* rtl/core/ntt_datapath.sv */
// Datapath: coefficient memory, butterfly arithmetic, twiddle and power registers.
`timescale 1ns / 1ps
`default_nettype none
module ntt_datapath import ntt_pkg::*; (
  input  wire   clk_i,
  input  wire   rst_ni,
  input  cmd_t  cmd_i,
  input  coef_t in_value_i,
  output sts_t  sts_o,
  output coef_t rd_data_o
);

  coef_t mem_q [N];
  coef_t rd_q;
  coef_t x_q;
  coef_t y_q;
  coef_t w_q;
  coef_t acc_q;
  coef_t b_q;
  coef_t wdata;
  coef_t mul_a;
  coef_t mul_b;
  coef_t prod;
  logic  mul_busy;
  logic  mul_done;

  always_comb begin
    unique case (cmd_i.wr_sel)
      WSEL_IN:   wdata = mod_add(in_value_i, '0);
      WSEL_RD:   wdata = rd_q;
      WSEL_X:    wdata = x_q;
      WSEL_SUM:  wdata = mod_add(x_q, y_q);
      WSEL_DIFF: wdata = mod_sub(x_q, y_q);
      WSEL_PROD: wdata = prod;
      default:   wdata = rd_q;
    endcase
  end

  always_comb begin
    unique case (cmd_i.mul_sel)
      MSEL_W_RD:   begin mul_a = w_q;   mul_b = rd_q;  end
      MSEL_W_ACC:  begin mul_a = w_q;   mul_b = acc_q; end
      MSEL_ACC_B:  begin mul_a = acc_q; mul_b = b_q;   end
      MSEL_B_B:    begin mul_a = b_q;   mul_b = b_q;   end
      MSEL_ACC_RD: begin mul_a = acc_q; mul_b = rd_q;  end
      default:     begin mul_a = w_q;   mul_b = rd_q;  end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.wr_en) begin
      mem_q[cmd_i.wr_addr] <= wdata;
    end
    if (cmd_i.rd_en) begin
      rd_q <= mem_q[cmd_i.rd_addr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.x_ld) begin
      x_q <= rd_q;
    end
    if (cmd_i.y_ld) begin
      y_q <= prod;
    end
    if (cmd_i.w_one) begin
      w_q <= coef_t'(1);
    end else if (cmd_i.w_ld) begin
      w_q <= prod;
    end
    if (cmd_i.pow_init) begin
      acc_q <= coef_t'(1);
      b_q   <= cmd_i.pow_base;
    end else begin
      if (cmd_i.acc_ld) begin
        acc_q <= prod;
      end
      if (cmd_i.b_ld) begin
        b_q <= prod;
      end
    end
  end

  ntt_mulmod u_mulmod (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cmd_i.mul_start),
    .a_i     (mul_a),
    .b_i     (mul_b),
    .prod_o  (prod),
    .busy_o  (mul_busy),
    .done_o  (mul_done)
  );

  assign sts_o.mul_busy = mul_busy;
  assign sts_o.mul_done = mul_done;
  assign rd_data_o      = rd_q;

endmodule
`default_nettype wire

/* rtl/core/ntt_ctrl.sv */
// Controller: sequences item handling, bit reversal, butterflies, powers and scaling.
`timescale 1ns / 1ps
`default_nettype none
module ntt_ctrl import ntt_pkg::*; (
  input  wire             clk_i,
  input  wire             rst_ni,
  input  wire             in_accept_i,
  input  wire [1:0]       in_action_i,
  input  addr_t           in_index_i,
  input  wire [LGW-1:0]   log_length_i,
  input  wire             direction_i,
  input  sts_t            sts_i,
  output cmd_t            cmd_o,
  output logic            idle_o,
  output logic            out_ld_o
);

  localparam logic [4:0] ST_IDLE   = 5'd0;
  localparam logic [4:0] ST_READ   = 5'd1;
  localparam logic [4:0] ST_SW_RA  = 5'd2;
  localparam logic [4:0] ST_SW_RB  = 5'd3;
  localparam logic [4:0] ST_SW_WA  = 5'd4;
  localparam logic [4:0] ST_SW_WB  = 5'd5;
  localparam logic [4:0] ST_PW_A   = 5'd6;
  localparam logic [4:0] ST_PW_AW  = 5'd7;
  localparam logic [4:0] ST_PW_B   = 5'd8;
  localparam logic [4:0] ST_PW_BW  = 5'd9;
  localparam logic [4:0] ST_BF_RA  = 5'd10;
  localparam logic [4:0] ST_BF_RB  = 5'd11;
  localparam logic [4:0] ST_BF_MY  = 5'd12;
  localparam logic [4:0] ST_BF_YW  = 5'd13;
  localparam logic [4:0] ST_BF_WA  = 5'd14;
  localparam logic [4:0] ST_BF_WB  = 5'd15;
  localparam logic [4:0] ST_BF_WW  = 5'd16;
  localparam logic [4:0] ST_SC_RD  = 5'd17;
  localparam logic [4:0] ST_SC_MUL = 5'd18;
  localparam logic [4:0] ST_SC_WT  = 5'd19;

  localparam logic MODE_BITREV  = 1'b0;
  localparam logic MODE_REVERSE = 1'b1;
  localparam logic RET_STAGE    = 1'b0;
  localparam logic RET_SCALE    = 1'b1;

  logic [4:0]     state_q, state_d;
  addr_t          i_q, i_d;
  logic [JW-1:0]  j_q, j_d;
  logic [LGW-1:0] s_q, s_d;
  coef_t          exp_q, exp_d;
  logic           ret_q, ret_d;
  logic           mode_q, mode_d;

  logic [LGW-1:0] lg;
  logic [LOGN:0]  lenv;
  addr_t          len_m1;
  logic [JW-1:0]  jlast;
  addr_t          half_w;
  logic [JW-1:0]  jmask;
  addr_t          bf_a;
  addr_t          bf_b;
  addr_t          sw_b;
  logic           sw_need;
  logic           sw_adv;

  always_comb begin
    if (log_length_i == '0) begin
      lg = LGW'(1);
    end else if (log_length_i > LGW'(LOGN)) begin
      lg = LGW'(LOGN);
    end else begin
      lg = log_length_i;
    end
  end

  assign lenv   = (LOGN + 1)'(1) << lg;
  assign len_m1 = addr_t'(lenv - (LOGN + 1)'(1));
  assign jlast  = JW'((lenv >> 1) - (LOGN + 1)'(1));

  // Butterfly j of a stage pairs positions that differ only in bit s-1.
  assign half_w = addr_t'(1) << (s_q - LGW'(1));
  assign jmask  = JW'(half_w - addr_t'(1));
  assign bf_a   = {j_q & ~jmask, 1'b0} | {1'b0, j_q & jmask};
  assign bf_b   = bf_a | half_w;

  assign sw_b    = (mode_q == MODE_BITREV) ? bit_rev(i_q, lg)
                                           : addr_t'(lenv - {1'b0, i_q});
  assign sw_need = (i_q < sw_b);

  always_comb begin
    state_d  = state_q;
    i_d      = i_q;
    j_d      = j_q;
    s_d      = s_q;
    exp_d    = exp_q;
    ret_d    = ret_q;
    mode_d   = mode_q;
    cmd_o    = '0;
    out_ld_o = 1'b0;
    sw_adv   = 1'b0;

    unique case (state_q)
      ST_IDLE: begin
        if (in_accept_i) begin
          unique case (in_action_i)
            ACT_WRITE: begin
              cmd_o.wr_en   = 1'b1;
              cmd_o.wr_addr = in_index_i;
              cmd_o.wr_sel  = WSEL_IN;
            end
            ACT_READ: begin
              cmd_o.rd_en   = 1'b1;
              cmd_o.rd_addr = in_index_i;
              state_d       = ST_READ;
            end
            ACT_RUN: begin
              i_d     = '0;
              mode_d  = MODE_BITREV;
              state_d = ST_SW_RA;
            end
            default: begin
            end
          endcase
        end
      end
      ST_READ: begin
        out_ld_o = 1'b1;
        state_d  = ST_IDLE;
      end
      ST_SW_RA: begin
        if (sw_need) begin
          cmd_o.rd_en   = 1'b1;
          cmd_o.rd_addr = i_q;
          state_d       = ST_SW_RB;
        end else if (mode_q == MODE_BITREV) begin
          sw_adv = 1'b1;
        end else begin
          // Reversal finished: compute the inverse of the length as len^(P-2).
          cmd_o.pow_init = 1'b1;
          cmd_o.pow_base = coef_t'(lenv);
          exp_d          = PM2;
          ret_d          = RET_SCALE;
          state_d        = ST_PW_A;
        end
      end
      ST_SW_RB: begin
        cmd_o.x_ld    = 1'b1;
        cmd_o.rd_en   = 1'b1;
        cmd_o.rd_addr = sw_b;
        state_d       = ST_SW_WA;
      end
      ST_SW_WA: begin
        cmd_o.wr_en   = 1'b1;
        cmd_o.wr_addr = i_q;
        cmd_o.wr_sel  = WSEL_RD;
        state_d       = ST_SW_WB;
      end
      ST_SW_WB: begin
        cmd_o.wr_en   = 1'b1;
        cmd_o.wr_addr = sw_b;
        cmd_o.wr_sel  = WSEL_X;
        sw_adv        = 1'b1;
      end
      ST_PW_A: begin
        if (exp_q[0]) begin
          cmd_o.mul_start = 1'b1;
          cmd_o.mul_sel   = MSEL_ACC_B;
          state_d         = ST_PW_AW;
        end else begin
          state_d = ST_PW_B;
        end
      end
      ST_PW_AW: begin
        if (sts_i.mul_done) begin
          cmd_o.acc_ld = 1'b1;
          state_d      = ST_PW_B;
        end
      end
      ST_PW_B: begin
        cmd_o.mul_start = 1'b1;
        cmd_o.mul_sel   = MSEL_B_B;
        state_d         = ST_PW_BW;
      end
      ST_PW_BW: begin
        if (sts_i.mul_done) begin
          cmd_o.b_ld = 1'b1;
          exp_d      = exp_q >> 1;
          if (exp_q[CW-1:1] == '0) begin
            if (ret_q == RET_STAGE) begin
              j_d     = '0;
              state_d = ST_BF_RA;
            end else begin
              i_d     = '0;
              state_d = ST_SC_RD;
            end
          end else begin
            state_d = ST_PW_A;
          end
        end
      end
      ST_BF_RA: begin
        cmd_o.rd_en   = 1'b1;
        cmd_o.rd_addr = bf_a;
        cmd_o.w_one   = ((j_q & jmask) == '0);
        state_d       = ST_BF_RB;
      end
      ST_BF_RB: begin
        cmd_o.x_ld    = 1'b1;
        cmd_o.rd_en   = 1'b1;
        cmd_o.rd_addr = bf_b;
        state_d       = ST_BF_MY;
      end
      ST_BF_MY: begin
        cmd_o.mul_start = 1'b1;
        cmd_o.mul_sel   = MSEL_W_RD;
        state_d         = ST_BF_YW;
      end
      ST_BF_YW: begin
        if (sts_i.mul_done) begin
          cmd_o.y_ld = 1'b1;
          state_d    = ST_BF_WA;
        end
      end
      ST_BF_WA: begin
        cmd_o.wr_en   = 1'b1;
        cmd_o.wr_addr = bf_a;
        cmd_o.wr_sel  = WSEL_SUM;
        state_d       = ST_BF_WB;
      end
      ST_BF_WB: begin
        cmd_o.wr_en     = 1'b1;
        cmd_o.wr_addr   = bf_b;
        cmd_o.wr_sel    = WSEL_DIFF;
        cmd_o.mul_start = 1'b1;
        cmd_o.mul_sel   = MSEL_W_ACC;
        state_d         = ST_BF_WW;
      end
      ST_BF_WW: begin
        if (sts_i.mul_done) begin
          cmd_o.w_ld = 1'b1;
          if (j_q == jlast) begin
            j_d = '0;
            if (s_q == lg) begin
              if (direction_i) begin
                i_d     = addr_t'(1);
                mode_d  = MODE_REVERSE;
                state_d = ST_SW_RA;
              end else begin
                state_d = ST_IDLE;
              end
            end else begin
              s_d            = s_q + LGW'(1);
              cmd_o.pow_init = 1'b1;
              cmd_o.pow_base = ROOT;
              exp_d          = PM1 >> (s_q + LGW'(1));
              ret_d          = RET_STAGE;
              state_d        = ST_PW_A;
            end
          end else begin
            j_d     = j_q + JW'(1);
            state_d = ST_BF_RA;
          end
        end
      end
      ST_SC_RD: begin
        cmd_o.rd_en   = 1'b1;
        cmd_o.rd_addr = i_q;
        state_d       = ST_SC_MUL;
      end
      ST_SC_MUL: begin
        cmd_o.mul_start = 1'b1;
        cmd_o.mul_sel   = MSEL_ACC_RD;
        state_d         = ST_SC_WT;
      end
      ST_SC_WT: begin
        if (sts_i.mul_done) begin
          cmd_o.wr_en   = 1'b1;
          cmd_o.wr_addr = i_q;
          cmd_o.wr_sel  = WSEL_PROD;
          if (i_q == len_m1) begin
            state_d = ST_IDLE;
          end else begin
            i_d     = i_q + addr_t'(1);
            state_d = ST_SC_RD;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase

    // Next position of a swap pass; the bit reversal ends in the first stage.
    if (sw_adv) begin
      if (mode_q == MODE_BITREV && i_q == len_m1) begin
        s_d            = LGW'(1);
        cmd_o.pow_init = 1'b1;
        cmd_o.pow_base = ROOT;
        exp_d          = PM1 >> 1;
        ret_d          = RET_STAGE;
        state_d        = ST_PW_A;
      end else begin
        i_d     = i_q + addr_t'(1);
        state_d = ST_SW_RA;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      i_q     <= '0;
      j_q     <= '0;
      s_q     <= '0;
      exp_q   <= '0;
      ret_q   <= RET_STAGE;
      mode_q  <= MODE_BITREV;
    end else begin
      state_q <= state_d;
      i_q     <= i_d;
      j_q     <= j_d;
      s_q     <= s_d;
      exp_q   <= exp_d;
      ret_q   <= ret_d;
      mode_q  <= mode_d;
    end
  end

  assign idle_o = (state_q == ST_IDLE);

endmodule
`default_nettype wire

/* rtl/core/ntt_mod_prime_transform_unit.sv */
// Top level of the number theoretic transform unit modulo 998244353.
//
//   channel  direction  handshake               payload
//   in       input      in_valid_i / in_stall_o    in_action_i, in_index_i, in_value_i
//   out      output     out_valid_o / out_stall_i  out_read_value_o, out_read_index_o
//   cfg      input      cfg_we_i                   cfg_index_i, cfg_wdata_i
//
// A run item performs (len/2) * log2(len) butterflies, plus the bit-reversal swaps and
// a twiddle power for each stage; in the inverse direction it also reverses the
// order and scales by the inverse of the length.
// The time is set by the shared bit-serial modular multiplier.
// Reset clears control state only; the coefficient memory is undefined until written.
// A finished read item waits in the output register; while it is held off, no new
// item is taken.
`timescale 1ns / 1ps
`default_nettype none
`include "ntt_mod_prime_transform_unit_macros.svh"
module ntt_mod_prime_transform_unit import ntt_pkg::*; (
  input  wire          clk_i,
  input  wire          rst_ni,
  input  wire          in_valid_i,
  output logic         in_stall_o,
  input  wire  [1:0]   in_action_i,
  input  addr_t        in_index_i,
  input  coef_t        in_value_i,
  output logic         out_valid_o,
  input  wire          out_stall_i,
  output coef_t        out_read_value_o,
  output addr_t        out_read_index_o,
  input  wire          cfg_we_i,
  input  wire  [1:0]   cfg_index_i,
  input  wire  [3:0]   cfg_wdata_i
);

  logic [LGW-1:0] log_length_q;
  logic           direction_q;
  logic           out_valid_q;
  coef_t          out_value_q;
  addr_t          out_index_q;
  addr_t          pend_index_q;
  logic           in_accept;
  logic           ctrl_idle;
  logic           out_ld;
  cmd_t           cmd;
  sts_t           sts;
  coef_t          rd_data;

  assign in_stall_o = !ctrl_idle || (out_valid_q && out_stall_i);
  assign in_accept  = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      log_length_q <= LGW'(LOGN);
      direction_q  <= 1'b0;
    end else if (cfg_we_i) begin
      if (cfg_index_i == CFG_LOG_LENGTH) begin
        log_length_q <= LGW'(cfg_wdata_i);
      end else if (cfg_index_i == CFG_DIRECTION) begin
        direction_q <= cfg_wdata_i[0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_ld) begin
      out_valid_q <= 1'b1;
    end else if (out_valid_q && !out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      pend_index_q <= in_index_i;
    end
    if (out_ld) begin
      out_value_q <= rd_data;
      out_index_q <= pend_index_q;
    end
  end

  ntt_ctrl u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_accept_i  (in_accept),
    .in_action_i  (in_action_i),
    .in_index_i   (in_index_i),
    .log_length_i (log_length_q),
    .direction_i  (direction_q),
    .sts_i        (sts),
    .cmd_o        (cmd),
    .idle_o       (ctrl_idle),
    .out_ld_o     (out_ld)
  );

  ntt_datapath u_datapath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .in_value_i (in_value_i),
    .sts_o      (sts),
    .rd_data_o  (rd_data)
  );

  assign out_valid_o      = out_valid_q;
  assign out_read_value_o = out_value_q;
  assign out_read_index_o = out_index_q;

  `NTT_ASSERT(a_read_gives_item, in_accept && in_action_i == ACT_READ, ##2 out_valid_o, "read item did not reach the output")
  `NTT_ASSERT(a_mul_free, cmd.mul_start, !sts.mul_busy, "multiplier started while busy")
  `NTT_ASSERT(a_out_slot_free, out_ld, !(out_valid_q && out_stall_i), "output register overwritten")

endmodule
`default_nettype wire

/* tb/ntt_mod_prime_transform_unit_test.sv */
// Self-checking testbench of the modular number theoretic transform unit.
`timescale 1ns / 1ps
module ntt_mod_prime_transform_unit_test;
  import ntt_pkg::*;

  localparam longint unsigned MODULUS = 64'd998244353;
  localparam longint unsigned CYCLE_LIMIT = 64'd4000000;
  localparam logic [1:0] ACT_UNUSED = 2'd3;
  localparam logic [1:0] CFG_UNUSED = 2'd2;

  typedef struct {
    logic [1:0] act;
    addr_t      idx;
    coef_t      val;
  } coef_op_t;

  typedef struct {
    coef_t value;
    addr_t index;
  } coef_read_t;

  logic  clk_i = 1'b0;
  logic  rst_ni = 1'b0;
  logic  in_valid = 1'b0;
  logic  in_stall_o;
  logic  [1:0] in_action = ACT_WRITE;
  addr_t in_index = '0;
  coef_t in_value = '0;
  logic  out_valid_o;
  logic  out_stall = 1'b0;
  coef_t out_read_value_o;
  addr_t out_read_index_o;
  logic  cfg_we = 1'b0;
  logic  [1:0] cfg_index = CFG_LOG_LENGTH;
  logic  [3:0] cfg_wdata = 4'd0;

  ntt_mod_prime_transform_unit u_dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid),
    .in_stall_o       (in_stall_o),
    .in_action_i      (in_action),
    .in_index_i       (in_index),
    .in_value_i       (in_value),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall),
    .out_read_value_o (out_read_value_o),
    .out_read_index_o (out_read_index_o),
    .cfg_we_i         (cfg_we),
    .cfg_index_i      (cfg_index),
    .cfg_wdata_i      (cfg_wdata)
  );

  always #5 clk_i = ~clk_i;

  coef_op_t   op_q[$];
  coef_read_t read_exp_q[$];
  coef_op_t   cur_op;
  coef_t      shadow_coef[N];
  bit         planned_written[N];
  logic [3:0] shadow_log = 4'd10;
  logic       shadow_dir = 1'b0;
  longint unsigned cycles = 0;
  int errors = 0;
  int n_reads = 0;
  int n_runs = 0;
  int n_results = 0;
  int hold_left = 0;
  bit hold_done = 1'b0;

  function automatic coef_t mul_residue(coef_t a, coef_t b);
    longint unsigned p;
    p = longint'(a) * longint'(b);
    return coef_t'(p % MODULUS);
  endfunction

  function automatic coef_t pow_residue(coef_t base, longint unsigned e);
    coef_t acc;
    acc = 30'd1;
    while (e != 0) begin
      if (e[0]) acc = mul_residue(acc, base);
      base = mul_residue(base, base);
      e = e >> 1;
    end
    return acc;
  endfunction

  // In-place transform of the shadow store with the current settings.
  task automatic transform_shadow();
    int lg, len, r, half, q, lo, hi;
    coef_t t, x, y, w, stp, inv;
    lg = (shadow_log < 1) ? 1 : (shadow_log > LOGN) ? LOGN : shadow_log;
    len = 1 << lg;
    for (int i = 0; i < len; i++) begin
      r = 0;
      for (int b = 0; b < lg; b++) r |= ((i >> b) & 1) << (lg - 1 - b);
      if (i < r) begin
        t = shadow_coef[i];
        shadow_coef[i] = shadow_coef[r];
        shadow_coef[r] = t;
      end
    end
    for (q = 2; q <= len; q = q * 2) begin
      half = q / 2;
      stp = pow_residue(coef_t'(ROOT), (MODULUS - 1) / q);
      for (int i = 0; i < len; i += q) begin
        w = 30'd1;
        for (int k = i; k < i + half; k++) begin
          x = shadow_coef[k];
          y = mul_residue(w, shadow_coef[k + half]);
          shadow_coef[k] = coef_t'((longint'(x) + y) % MODULUS);
          shadow_coef[k + half] = coef_t'((longint'(x) + MODULUS - y) % MODULUS);
          w = mul_residue(w, stp);
        end
      end
    end
    if (shadow_dir) begin
      lo = 1;
      hi = len - 1;
      while (lo < hi) begin
        t = shadow_coef[lo];
        shadow_coef[lo] = shadow_coef[hi];
        shadow_coef[hi] = t;
        lo++;
        hi--;
      end
      inv = pow_residue(coef_t'(len), MODULUS - 2);
      for (int i = 0; i < len; i++) shadow_coef[i] = mul_residue(shadow_coef[i], inv);
    end
  endtask

  task automatic apply_op(coef_op_t op);
    coef_read_t e;
    case (op.act)
      ACT_WRITE: shadow_coef[op.idx] = coef_t'(longint'(op.val) % MODULUS);
      ACT_RUN: begin
        transform_shadow();
        n_runs++;
      end
      ACT_READ: begin
        e.value = shadow_coef[op.idx];
        e.index = op.idx;
        read_exp_q.push_back(e);
        n_reads++;
      end
      default: ;
    endcase
  endtask

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("ntt_mod_prime_transform_unit_test: FAIL");
      $finish;
    end
  end

  // Item driver; a quiet window runs without any idle cycles.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall_o) apply_op(cur_op);
      if (!in_valid || !in_stall_o) begin
        if (op_q.size() > 0 &&
            ((cycles > 3000 && cycles < 9000) || $urandom_range(99) >= 38)) begin
          cur_op = op_q.pop_front();
          in_valid <= 1'b1;
          in_action <= cur_op.act;
          in_index <= cur_op.idx;
          in_value <= cur_op.val;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Result monitor with one long hold-off to back up the block.
  always @(posedge clk_i or negedge rst_ni) begin
    coef_read_t e;
    if (!rst_ni) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid_o && !out_stall) begin
        n_results++;
        if (read_exp_q.size() == 0) begin
          $error("unexpected result index %0d value %0d", out_read_index_o, out_read_value_o);
          errors++;
        end else begin
          e = read_exp_q.pop_front();
          if (out_read_value_o !== e.value) begin
            $error("read_value expected %0d actual %0d", e.value, out_read_value_o);
            errors++;
          end
          if (out_read_index_o !== e.index) begin
            $error("read_index expected %0d actual %0d", e.index, out_read_index_o);
            errors++;
          end
        end
      end
      if (hold_left > 0) begin
        hold_left <= hold_left - 1;
        out_stall <= 1'b1;
      end else if (!hold_done && n_results >= 60) begin
        hold_done <= 1'b1;
        hold_left <= 400;
        out_stall <= 1'b1;
      end else begin
        out_stall <= ($urandom_range(99) < 38) && !(cycles > 5000 && cycles < 8000);
      end
    end
  end

  task automatic add_op(logic [1:0] act, addr_t idx, coef_t val);
    coef_op_t op;
    op.act = act;
    op.idx = idx;
    op.val = val;
    if (act == ACT_WRITE) planned_written[idx] = 1'b1;
    op_q.push_back(op);
  endtask

  task automatic set_reg(logic [1:0] idx, logic [3:0] data);
    @(posedge clk_i);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(posedge clk_i);
    cfg_we <= 1'b0;
    if (idx == CFG_LOG_LENGTH) shadow_log = data;
    else if (idx == CFG_DIRECTION) shadow_dir = data[0];
  endtask

  // Waits until every item is taken and every read has returned.
  task automatic drain();
    do @(negedge clk_i);
    while (op_q.size() != 0 || in_valid || read_exp_q.size() != 0);
    repeat (20) @(negedge clk_i);
  endtask

  function automatic addr_t pick_written();
    addr_t a;
    do a = addr_t'($urandom_range(N - 1));
    while (!planned_written[a]);
    return a;
  endfunction

  function automatic coef_t rand_coef();
    return ($urandom_range(3) == 0) ? coef_t'($urandom) : coef_t'($urandom_range(998244352));
  endfunction

  initial begin
    int lg, len, roll;
    int log_choices[7] = '{0, 1, 2, 3, 4, 5, 6};
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed: smallest length, extreme values, unreduced value, unused action and config index.
    set_reg(CFG_LOG_LENGTH, 4'd1);
    set_reg(CFG_DIRECTION, 4'd0);
    set_reg(CFG_UNUSED, 4'd15);
    add_op(ACT_WRITE, 10'd0, 30'd0);
    add_op(ACT_WRITE, 10'd1, 30'd998244352);
    add_op(ACT_WRITE, 10'd1023, 30'h3FFFFFFF);
    add_op(ACT_WRITE, 10'd512, 30'd998244353);
    add_op(ACT_READ, 10'd1023, 30'h3FFFFFFF);
    add_op(ACT_READ, 10'd512, 30'd0);
    add_op(ACT_UNUSED, 10'd1023, 30'h3FFFFFFF);
    add_op(ACT_RUN, 10'd0, 30'd0);
    add_op(ACT_READ, 10'd0, 30'd0);
    add_op(ACT_READ, 10'd1, 30'd0);
    add_op(ACT_WRITE, 10'd0, 30'd1);
    add_op(ACT_WRITE, 10'd1, 30'd2);
    add_op(ACT_RUN, 10'd0, 30'd0);
    add_op(ACT_READ, 10'd0, 30'd0);
    drain();
    set_reg(CFG_DIRECTION, 4'd1);
    add_op(ACT_RUN, 10'd0, 30'd0);
    add_op(ACT_READ, 10'd0, 30'd0);
    add_op(ACT_READ, 10'd1, 30'd0);
    drain();

    // Random phases: fill the transform prefix, then mixed traffic.
    for (int ph = 0; ph < 9; ph++) begin
      set_reg(CFG_LOG_LENGTH, 4'(log_choices[$urandom_range(6)]));
      set_reg(CFG_DIRECTION, 4'($urandom_range(1)));
      lg = (shadow_log < 1) ? 1 : shadow_log;
      len = 1 << lg;
      for (int i = 0; i < len; i++) add_op(ACT_WRITE, addr_t'(i), rand_coef());
      for (int i = 0; i < 50; i++) begin
        roll = $urandom_range(99);
        if (roll < 30) add_op(ACT_WRITE, addr_t'($urandom), rand_coef());
        else if (roll < 35) add_op(ACT_RUN, addr_t'($urandom), coef_t'($urandom));
        else if (roll < 38) add_op(ACT_UNUSED, addr_t'($urandom), coef_t'($urandom));
        else if (roll < 70) add_op(ACT_READ, addr_t'($urandom_range(len - 1)), coef_t'($urandom));
        else add_op(ACT_READ, pick_written(), coef_t'($urandom));
      end
      // A closing read also marks the end of any run still in progress.
      add_op(ACT_READ, 10'd0, 30'd0);
      drain();
    end
    repeat (50) @(negedge clk_i);

    $display("Covered %0d transforms and %0d reads over lengths 2 to 64, both directions.",
             n_runs, n_reads);
    if (errors == 0 && read_exp_q.size() == 0) begin
      $display("ntt_mod_prime_transform_unit_test: PASS");
    end else begin
      $display("ntt_mod_prime_transform_unit_test: FAIL");
    end
    $finish;
  end

endmodule
